[rtl/epoch_ms_to_calendar_date_macros.svh]
// assertion macros used by the checker
`ifndef EPOCH_MS_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_MS_TO_CALENDAR_DATE_MACROS_SVH

// property checked outside reset
`define EMC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that also holds across reset
`define EMC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/emc_pkg.sv]
package emc_pkg;

   // default width of the time input
   localparam int TIME_BITS_DEF = 48;

   // divisors and calendar lengths
   localparam int unsigned MS_PER_DAY      = 86400000;
   localparam int unsigned MS_PER_SEC      = 1000;
   localparam int unsigned SEC_PER_MIN     = 60;
   localparam int unsigned DAYS_400Y       = 146097;
   localparam int unsigned DAYS_100Y_FIRST = 36525;
   localparam int unsigned DAYS_100Y       = 36524;
   localparam int unsigned DAYS_4Y         = 1461;
   localparam int unsigned DAYS_4Y_SHORT   = 1460;
   localparam int unsigned DAYS_LEAP       = 366;
   localparam int unsigned DAYS_PLAIN      = 365;
   localparam int unsigned EPOCH_YEAR      = 2000;
   localparam int unsigned FEB29_INDEX     = 59;
   localparam int unsigned WEEKDAY_OFFSET  = 5;
   localparam int          NUM_MONTHS      = 12;

   // century position within a 400-year cycle
   typedef struct packed {
      logic [1:0] cent;
      logic       quad_base;
      logic       quad_short;
   } cent_type;

   // broken-down date
   typedef struct packed {
      logic [3:0]  mon;
      logic [4:0]  dom;
      logic [8:0]  doy;
      logic [13:0] yr;
      logic        leap;
   } date_type;

   // first day index of each month in a leap-year layout
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] res;
      case (idx)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd60;
         4'd3:    res = 9'd91;
         4'd4:    res = 9'd121;
         4'd5:    res = 9'd152;
         4'd6:    res = 9'd182;
         4'd7:    res = 9'd213;
         4'd8:    res = 9'd244;
         4'd9:    res = 9'd274;
         4'd10:   res = 9'd305;
         4'd11:   res = 9'd335;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

[rtl/emc_cdiv.sv]
module emc_cdiv #(
   parameter int          NW  = 16,
   parameter int          QW  = 8,
   parameter int unsigned DVR = 7,
   parameter int          SW  = 8,
   parameter int          RW  = $clog2(DVR)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [NW-1:0] in_num,
   input  logic [SW-1:0] in_side,
   output logic          out_vld,
   output logic [QW-1:0] out_quo,
   output logic [RW-1:0] out_rem,
   output logic [SW-1:0] out_side
);

   // trailing zero bits of a constant
   function automatic int low_zeros(input longint unsigned v);
      longint unsigned x;
      int              n;
      x = v;
      n = 0;
      while (x != 0 && x[0] == 1'b0) begin
         x = x >> 1;
         n++;
      end
      return n;
   endfunction

   // divisor split into a power of two and an odd part, reciprocal of the odd part
   localparam int              TZ    = low_zeros(64'(DVR));
   localparam longint unsigned ODD   = 64'(DVR) >> TZ;
   localparam int              AW    = NW - TZ;
   localparam int              OW    = $clog2(ODD + 1);
   localparam int              MW    = (AW - OW + 1 > 0) ? AW - OW + 1 : 1;
   localparam int              HW    = (AW + 1) / 2;
   localparam int              UW    = AW - HW;
   localparam int              PW    = AW + MW;
   localparam int              EW    = (NW > QW + RW) ? NW : QW + RW;
   localparam logic [MW-1:0]   RECIP = MW'((64'd1 << AW) / ODD);

   // stage 1: numerator halves times the reciprocal
   logic [AW-1:0]    num_a;
   logic [HW+MW-1:0] plo_in;
   logic [UW+MW-1:0] phi_in;
   logic             vld1_ff;
   logic [HW+MW-1:0] plo_ff;
   logic [UW+MW-1:0] phi_ff;
   logic [NW-1:0]    num1_ff;
   logic [SW-1:0]    side1_ff;

   assign num_a  = in_num[NW-1:TZ];
   assign plo_in = (HW+MW)'(num_a[HW-1:0]) * (HW+MW)'(RECIP);
   assign phi_in = (UW+MW)'(num_a[AW-1:HW]) * (UW+MW)'(RECIP);

   // stage 2: quotient estimate, low by at most one
   logic [PW-1:0] prod;
   logic [QW-1:0] qe_in;
   logic          vld2_ff;
   logic [QW-1:0] qe2_ff;
   logic [NW-1:0] num2_ff;
   logic [SW-1:0] side2_ff;

   assign prod  = (PW'(phi_ff) << HW) + PW'(plo_ff);
   assign qe_in = QW'(prod >> AW);

   // stage 3: remainder of the estimate, below twice the divisor
   logic [QW+RW-1:0] qd;
   logic [EW-1:0]    diff;
   logic [RW:0]      re_in;
   logic             vld3_ff;
   logic [QW-1:0]    qe3_ff;
   logic [RW:0]      re3_ff;
   logic [SW-1:0]    side3_ff;

   assign qd    = (QW+RW)'(qe2_ff) * (QW+RW)'(DVR);
   assign diff  = EW'(num2_ff) - EW'(qd);
   assign re_in = (RW+1)'(diff);

   // stage 4: one correction step
   logic          ge;
   logic [QW-1:0] quo_in;
   logic [RW-1:0] rem_in;
   logic          vld4_ff;
   logic [QW-1:0] quo4_ff;
   logic [RW-1:0] rem4_ff;
   logic [SW-1:0] side4_ff;

   assign ge     = re3_ff >= (RW+1)'(DVR);
   assign quo_in = qe3_ff + QW'(ge);
   assign rem_in = ge ? RW'(re3_ff - (RW+1)'(DVR)) : RW'(re3_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         num1_ff  <= in_num;
         side1_ff <= in_side;
         qe2_ff   <= qe_in;
         num2_ff  <= num1_ff;
         side2_ff <= side1_ff;
         qe3_ff   <= qe2_ff;
         re3_ff   <= re_in;
         side3_ff <= side2_ff;
         quo4_ff  <= quo_in;
         rem4_ff  <= rem_in;
         side4_ff <= side3_ff;
      end
   end

   assign out_vld  = vld4_ff;
   assign out_quo  = quo4_ff;
   assign out_rem  = rem4_ff;
   assign out_side = side4_ff;

endmodule

[rtl/emc_ymd.sv]
module emc_ymd #(
   parameter int QBW = 5,
   parameter int SW  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  logic [QBW-1:0]   in_q,
   input  emc_pkg::cent_type in_cent,
   input  logic [4:0]       in_y4q,
   input  logic [10:0]      in_rq,
   input  logic [SW-1:0]    in_side,
   output logic             out_vld,
   output emc_pkg::date_type out_date,
   output logic [SW-1:0]    out_side
);

   import emc_pkg::*;

   localparam int YW = QBW + 13;

   // stage 1: year within the quad and day within the year
   logic [4:0]     y4;
   logic [1:0]     y_in;
   logic [8:0]     doy_in;
   logic           leap_in;
   logic [10:0]    t;
   logic           vld1_ff;
   logic [4:0]     y4_ff;
   logic [1:0]     y_ff;
   logic [8:0]     doy1_ff;
   logic           leap1_ff;
   logic [QBW-1:0] q_ff;
   logic [1:0]     cent_ff;
   logic [SW-1:0]  side1_ff;

   assign y4 = in_y4q + 5'(in_cent.quad_base);
   assign t  = in_rq - 11'(DAYS_LEAP);

   always_comb begin
      if (in_cent.quad_short) begin
         if (in_rq >= 11'(3 * DAYS_PLAIN)) begin
            y_in   = 2'd3;
            doy_in = 9'(in_rq - 11'(3 * DAYS_PLAIN));
         end else if (in_rq >= 11'(2 * DAYS_PLAIN)) begin
            y_in   = 2'd2;
            doy_in = 9'(in_rq - 11'(2 * DAYS_PLAIN));
         end else if (in_rq >= 11'(DAYS_PLAIN)) begin
            y_in   = 2'd1;
            doy_in = 9'(in_rq - 11'(DAYS_PLAIN));
         end else begin
            y_in   = 2'd0;
            doy_in = 9'(in_rq);
         end
      end else if (in_rq < 11'(DAYS_LEAP)) begin
         y_in   = 2'd0;
         doy_in = 9'(in_rq);
      end else if (t >= 11'(2 * DAYS_PLAIN)) begin
         y_in   = 2'd3;
         doy_in = 9'(t - 11'(2 * DAYS_PLAIN));
      end else if (t >= 11'(DAYS_PLAIN)) begin
         y_in   = 2'd2;
         doy_in = 9'(t - 11'(DAYS_PLAIN));
      end else begin
         y_in   = 2'd1;
         doy_in = 9'(t);
      end
   end

   // leap when first year of a quad, unless a non-first century's first quad
   assign leap_in = (y_in == 2'd0) && ((y4 != 5'd0) || (in_cent.cent == 2'd0));

   // stage 2: full year and february correction
   logic [YW-1:0] year_full;
   logic [8:0]    r2_in;
   logic          vld2_ff;
   logic [13:0]   yr2_ff;
   logic [8:0]    r2_ff;
   logic [8:0]    doy2_ff;
   logic          leap2_ff;
   logic [SW-1:0] side2_ff;

   assign year_full = YW'(EPOCH_YEAR) + YW'(q_ff) * YW'(400) + YW'(cent_ff) * YW'(100)
                    + YW'({y4_ff, 2'b00}) + YW'(y_ff);
   assign r2_in = (!leap1_ff && doy1_ff >= 9'(FEB29_INDEX)) ? doy1_ff + 9'd1 : doy1_ff;

   // stage 3: month search over the month starts
   logic [3:0]    mon_idx;
   logic [4:0]    dom_in;
   logic          vld3_ff;
   date_type      date_ff;
   logic [SW-1:0] side3_ff;

   always_comb begin
      mon_idx = 4'd0;
      for (int k = 1; k < NUM_MONTHS; k++) begin
         if (r2_ff >= month_start(4'(k))) begin
            mon_idx = mon_idx + 4'd1;
         end
      end
   end

   assign dom_in = 5'(r2_ff - month_start(mon_idx) + 9'd1);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         y4_ff         <= y4;
         y_ff          <= y_in;
         doy1_ff       <= doy_in;
         leap1_ff      <= leap_in;
         q_ff          <= in_q;
         cent_ff       <= in_cent.cent;
         side1_ff      <= in_side;
         yr2_ff        <= year_full[13:0];
         r2_ff         <= r2_in;
         doy2_ff       <= doy1_ff + 9'd1;
         leap2_ff      <= leap1_ff;
         side2_ff      <= side1_ff;
         date_ff.mon   <= mon_idx + 4'd1;
         date_ff.dom   <= dom_in;
         date_ff.doy   <= doy2_ff;
         date_ff.yr    <= yr2_ff;
         date_ff.leap  <= leap2_ff;
         side3_ff      <= side2_ff;
      end
   end

   assign out_vld  = vld3_ff;
   assign out_date = date_ff;
   assign out_side = side3_ff;

endmodule

[rtl/epoch_ms_to_calendar_date.sv]
// pipeline: seven four-stage constant dividers, the three date stages and two single registers,
// the same for every TIME_BITS
// throughput: one transfer per cycle, the whole pipeline advances unless the result stalls
// reset: synchronous, clears the valid bits of every stage, including that of the result register
module epoch_ms_to_calendar_date #(
   parameter int TIME_BITS = emc_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // time_ms in the low TIME_BITS bits
   input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // millisecond, second_of_minute, minute_of_hour, hour_of_day, weekday,
   // day_in_month, month_number, day_in_year, year_number, leap_flag
   output logic [63:0]                         rsp_tdata
);

   import emc_pkg::*;

   localparam int DW   = TIME_BITS - 26;
   localparam int QBW  = (DW > 17) ? DW - 17 : 1;
   localparam int TODW = 27;

   typedef struct packed {
      logic [DW-1:0]   d;
      logic [TODW-1:0] tod;
      logic [QBW-1:0]  q;
      cent_type        cent;
      date_type        date;
      logic [2:0]      wday;
      logic [9:0]      ms;
      logic [5:0]      sec;
   } acc_type;

   localparam int SW = $bits(acc_type);

   logic en;
   logic rsp_vld_ff;
   logic [63:0] rsp_data_ff;

   // whole pipeline moves unless the result is held
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // days and time of day
   logic            vld_a;
   logic [DW-1:0]   quo_a;
   logic [TODW-1:0] rem_a;
   acc_type         side_a;
   acc_type         acc_a;

   emc_cdiv #(.NW(TIME_BITS), .QW(DW), .DVR(MS_PER_DAY), .SW(SW)) u_div_day (
      .clock, .reset, .en,
      .in_vld(req_tvalid), .in_num(req_tdata[TIME_BITS-1:0]), .in_side(SW'(0)),
      .out_vld(vld_a), .out_quo(quo_a), .out_rem(rem_a), .out_side(side_a)
   );

   always_comb begin
      acc_a     = side_a;
      acc_a.d   = quo_a;
      acc_a.tod = rem_a;
   end

   // 400-year cycles
   logic           vld_b;
   logic [QBW-1:0] quo_b;
   logic [17:0]    rem_b;
   acc_type        side_b;

   emc_cdiv #(.NW(DW), .QW(QBW), .DVR(DAYS_400Y), .SW(SW)) u_div_400y (
      .clock, .reset, .en,
      .in_vld(vld_a), .in_num(acc_a.d), .in_side(acc_a),
      .out_vld(vld_b), .out_quo(quo_b), .out_rem(rem_b), .out_side(side_b)
   );

   // century within the cycle and start of the 4-year division
   logic [16:0] s_c;
   logic [15:0] rr_c;
   cent_type    cent_in;
   logic [15:0] num_c_in;
   logic        vld_c_ff;
   acc_type     acc_c_ff;
   logic [15:0] num_c_ff;

   assign s_c = 17'(rem_b - 18'(DAYS_100Y_FIRST));

   always_comb begin
      if (rem_b < 18'(DAYS_100Y_FIRST)) begin
         cent_in.cent = 2'd0;
         rr_c         = rem_b[15:0];
      end else if (s_c >= 17'(2 * DAYS_100Y)) begin
         cent_in.cent = 2'd3;
         rr_c         = 16'(s_c - 17'(2 * DAYS_100Y));
      end else if (s_c >= 17'(DAYS_100Y)) begin
         cent_in.cent = 2'd2;
         rr_c         = 16'(s_c - 17'(DAYS_100Y));
      end else begin
         cent_in.cent = 2'd1;
         rr_c         = s_c[15:0];
      end
      cent_in.quad_short = (cent_in.cent != 2'd0) && (rr_c < 16'(DAYS_4Y_SHORT));
      cent_in.quad_base  = (cent_in.cent != 2'd0) && !cent_in.quad_short;
      num_c_in = cent_in.quad_base ? rr_c - 16'(DAYS_4Y_SHORT) : rr_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (en) begin
         vld_c_ff <= vld_b;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_c_ff      <= side_b;
         acc_c_ff.q    <= quo_b;
         acc_c_ff.cent <= cent_in;
         num_c_ff      <= num_c_in;
      end
   end

   // 4-year groups
   logic        vld_d;
   logic [4:0]  quo_d;
   logic [10:0] rem_d;
   acc_type     side_d;

   emc_cdiv #(.NW(16), .QW(5), .DVR(DAYS_4Y), .SW(SW)) u_div_4y (
      .clock, .reset, .en,
      .in_vld(vld_c_ff), .in_num(num_c_ff), .in_side(acc_c_ff),
      .out_vld(vld_d), .out_quo(quo_d), .out_rem(rem_d), .out_side(side_d)
   );

   // year, month and day
   logic     vld_e;
   date_type date_e;
   acc_type  side_e;
   acc_type  acc_e;

   emc_ymd #(.QBW(QBW), .SW(SW)) u_ymd (
      .clock, .reset, .en,
      .in_vld(vld_d), .in_q(side_d.q), .in_cent(side_d.cent), .in_y4q(quo_d),
      .in_rq(rem_d), .in_side(side_d),
      .out_vld(vld_e), .out_date(date_e), .out_side(side_e)
   );

   always_comb begin
      acc_e      = side_e;
      acc_e.date = date_e;
   end

   // day of week
   logic          vld_f;
   logic [DW-2:0] quo_f;
   logic [2:0]    rem_f;
   acc_type       side_f;
   acc_type       acc_f;

   emc_cdiv #(.NW(DW + 1), .QW(DW - 1), .DVR(7), .SW(SW)) u_div_week (
      .clock, .reset, .en,
      .in_vld(vld_e), .in_num({1'b0, acc_e.d} + (DW + 1)'(WEEKDAY_OFFSET)),
      .in_side(acc_e),
      .out_vld(vld_f), .out_quo(quo_f), .out_rem(rem_f), .out_side(side_f)
   );

   always_comb begin
      acc_f      = side_f;
      acc_f.wday = rem_f + 3'd1;
   end

   // seconds of the day
   logic        vld_g;
   logic [17:0] quo_g;
   logic [9:0]  rem_g;
   acc_type     side_g;
   acc_type     acc_g;

   emc_cdiv #(.NW(TODW), .QW(18), .DVR(MS_PER_SEC), .SW(SW)) u_div_sec (
      .clock, .reset, .en,
      .in_vld(vld_f), .in_num(acc_f.tod), .in_side(acc_f),
      .out_vld(vld_g), .out_quo(quo_g), .out_rem(rem_g), .out_side(side_g)
   );

   always_comb begin
      acc_g    = side_g;
      acc_g.ms = rem_g;
   end

   // minutes of the day
   logic        vld_h;
   logic [11:0] quo_h;
   logic [5:0]  rem_h;
   acc_type     side_h;
   acc_type     acc_h;

   emc_cdiv #(.NW(17), .QW(12), .DVR(SEC_PER_MIN), .SW(SW)) u_div_min (
      .clock, .reset, .en,
      .in_vld(vld_g), .in_num(quo_g[16:0]), .in_side(acc_g),
      .out_vld(vld_h), .out_quo(quo_h), .out_rem(rem_h), .out_side(side_h)
   );

   always_comb begin
      acc_h     = side_h;
      acc_h.sec = rem_h;
   end

   // hours of the day
   logic       vld_i;
   logic [5:0] quo_i;
   logic [5:0] rem_i;
   acc_type    side_i;

   emc_cdiv #(.NW(11), .QW(6), .DVR(SEC_PER_MIN), .SW(SW)) u_div_hour (
      .clock, .reset, .en,
      .in_vld(vld_h), .in_num(quo_h[10:0]), .in_side(acc_h),
      .out_vld(vld_i), .out_quo(quo_i), .out_rem(rem_i), .out_side(side_i)
   );

   // result register
   logic [63:0] rsp_data_in;

   assign rsp_data_in = {1'b0, side_i.date.leap, side_i.date.yr, side_i.date.doy,
                         side_i.date.mon, side_i.date.dom, side_i.wday, quo_i[4:0],
                         rem_i, side_i.sec, side_i.ms};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/emc_check.sv]
`include "epoch_ms_to_calendar_date_macros.svh"

module emc_check #(
   parameter int TIME_BITS = emc_pkg::TIME_BITS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((TIME_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [63:0]                         rsp_tdata
);

   // a held result stays offered
   `EMC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")

   // input side is open whenever no result waits
   `EMC_ASSERT(a_req_open, !rsp_tvalid |-> req_tready, "input blocked with empty result stage")

   // weekday, day and month never zero, month at most twelve
   `EMC_ASSERT(a_rsp_range, rsp_tvalid |-> rsp_tdata[29:27] != 3'd0 && rsp_tdata[34:30] != 5'd0 && rsp_tdata[38:35] != 4'd0 && rsp_tdata[38:35] <= 4'd12, "date field out of range")

   // no result straight after reset
   `EMC_ASSERT_RST(a_rst_empty, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind epoch_ms_to_calendar_date emc_check #(.TIME_BITS(TIME_BITS)) u_check (.*);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int TB_TIME_BITS = 48;
   localparam int DATA_W       = ((TB_TIME_BITS + 7) / 8) * 8;
   localparam int LATENCY      = 33;
   localparam int NUM_RANDOM   = 600;

   typedef struct packed {
      logic        leap;
      logic [13:0] year;
      logic [8:0]  doy;
      logic [3:0]  month;
      logic [4:0]  dom;
      logic [2:0]  wday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  msec;
   } calendar_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // time_ms
   logic [DATA_W-1:0]   req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // millisecond, second_of_minute, minute_of_hour, hour_of_day, weekday,
   // day_in_month, month_number, day_in_year, year_number, leap_flag
   logic [63:0]         rsp_tdata;

   logic [DATA_W-1:0]   pending_times[$];
   calendar_type        expected_dates[$];
   int                  error_count = 0;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   bit                  hold_sender;

   epoch_ms_to_calendar_date #(.TIME_BITS(TB_TIME_BITS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit is_leap_year(input longint unsigned yr);
      return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
   endfunction

   // break a millisecond count into the calendar date, year by year arithmetic
   function automatic calendar_type to_calendar(input logic [DATA_W-1:0] raw);
      longint unsigned ms, tod, days, rem, yr, ylen, mlen;
      int              mon;
      calendar_type    c;
      ms   = longint'(raw[TB_TIME_BITS-1:0]);
      tod  = ms % 64'd86400000;
      days = ms / 64'd86400000;
      c.msec   = 10'(tod % 1000);
      c.second = 6'((tod / 1000) % 60);
      c.minute = 6'((tod / 60000) % 60);
      c.hour   = 5'(tod / 3600000);
      c.wday   = 3'((days + 5) % 7 + 1);
      // whole 400-year cycles, then single years
      yr  = 2000 + 400 * (days / 146097);
      rem = days % 146097;
      ylen = is_leap_year(yr) ? 366 : 365;
      while (rem >= ylen) begin
         rem -= ylen;
         yr++;
         ylen = is_leap_year(yr) ? 366 : 365;
      end
      c.doy  = 9'(rem + 1);
      c.year = yr[13:0];
      c.leap = is_leap_year(yr);
      mon = 1;
      forever begin
         case (mon)
            2:       mlen = c.leap ? 29 : 28;
            4, 6, 9, 11: mlen = 30;
            default: mlen = 31;
         endcase
         if (rem < mlen || mon == 12) break;
         rem -= mlen;
         mon++;
      end
      c.month = 4'(mon);
      c.dom   = 5'(rem + 1);
      return c;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_dates.push_back(to_calendar(req_tdata));
         if (pending_times.size() > 0 && !hold_sender &&
             $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_times.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      calendar_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(calendar_type)-1:0];
            if (expected_dates.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               want = expected_dates.pop_front();
               if (got.msec != want.msec) report_mismatch("millisecond", got.msec, want.msec);
               if (got.second != want.second)
                  report_mismatch("second_of_minute", got.second, want.second);
               if (got.minute != want.minute)
                  report_mismatch("minute_of_hour", got.minute, want.minute);
               if (got.hour != want.hour) report_mismatch("hour_of_day", got.hour, want.hour);
               if (got.wday != want.wday) report_mismatch("weekday", got.wday, want.wday);
               if (got.dom != want.dom) report_mismatch("day_in_month", got.dom, want.dom);
               if (got.month != want.month)
                  report_mismatch("month_number", got.month, want.month);
               if (got.doy != want.doy) report_mismatch("day_in_year", got.doy, want.doy);
               if (got.year != want.year) report_mismatch("year_number", got.year, want.year);
               if (got.leap != want.leap) report_mismatch("leap_flag", got.leap, want.leap);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [DATA_W-1:0] ms_at_day(input longint unsigned day,
                                                   input longint unsigned msd);
      return DATA_W'(day * 64'd86400000 + msd);
   endfunction

   // stimulus and end of run
   initial begin
      longint unsigned max_t;
      logic [DATA_W-1:0] v;
      send_idle_pct = 8;
      recv_idle_pct = 82;
      hold_sender   = 1'b0;
      reset         = 1'b1;
      max_t = (64'd1 << TB_TIME_BITS) - 1;

      // directed: extremes, leap days, century boundaries
      pending_times.push_back('0);
      pending_times.push_back(DATA_W'(max_t));
      pending_times.push_back({DATA_W{1'b1}});
      pending_times.push_back(ms_at_day(0, 86399999));
      pending_times.push_back(ms_at_day(59, 0));            // 29 feb 2000
      pending_times.push_back(ms_at_day(365, 43200000));    // 31 dec 2000
      pending_times.push_back(ms_at_day(366 + 58, 1));      // 28 feb 2001
      pending_times.push_back(ms_at_day(366 + 59, 1));      // 1 mar 2001
      pending_times.push_back(ms_at_day(36524, 5));         // 31 dec 2099
      pending_times.push_back(ms_at_day(36525, 7));         // 1 jan 2100
      pending_times.push_back(ms_at_day(36525 + 59, 0));    // 1 mar 2100, not leap
      pending_times.push_back(ms_at_day(36525 + 1460, 0));  // 1 jan 2104
      pending_times.push_back(ms_at_day(36525 + 1460 + 59, 0)); // 29 feb 2104
      pending_times.push_back(ms_at_day(146096, 86399999)); // 31 dec 2399
      pending_times.push_back(ms_at_day(146097, 0));        // 1 jan 2400
      pending_times.push_back(ms_at_day(146097 + 59, 0));   // 29 feb 2400
      pending_times.push_back(48'haaaa_aaaa_aaaa);
      pending_times.push_back(48'h5555_5555_5555);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         case ($urandom_range(3))
            0: v = DATA_W'({$urandom, $urandom});
            1: v = ms_at_day($urandom_range(3000000), $urandom_range(86399999));
            2: v = ms_at_day($urandom_range(40000), $urandom_range(86399999));
            default: v = DATA_W'(max_t - $urandom_range(1000000));
         endcase
         pending_times.push_back(v);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // idling phases, with a full drain in between
      wait (pending_times.size() < 400);
      @(posedge clock);
      hold_sender <= 1'b1;
      wait (expected_dates.size() == 0 && !req_tvalid);
      repeat (LATENCY + 10) @(posedge clock);
      wait (expected_dates.size() == 0);
      hold_sender   <= 1'b0;
      send_idle_pct <= 82;
      recv_idle_pct <= 8;
      wait (pending_times.size() < 200);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      wait (pending_times.size() == 0);
      @(posedge clock);
      wait (!req_tvalid);
      wait (expected_dates.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // timeout
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule

[epoch_ms_to_calendar_date.f]
+incdir+rtl
rtl/emc_pkg.sv
rtl/emc_cdiv.sv
rtl/emc_ymd.sv
rtl/epoch_ms_to_calendar_date.sv
rtl/emc_check.sv
bench/tb.sv
